// ----- hdl/mrfp_pkg.sv -----
`timescale 1ns / 1ps

package mrfp_pkg;

    localparam logic [7:0] START_MARK  = 8'h24;
    localparam logic [7:0] TAIL_MARK   = 8'hFE;
    localparam logic [7:0] DEV_IR      = 8'h02;
    localparam logic [7:0] DEV_ZOOM    = 8'h03;
    localparam logic [7:0] DEV_FOCUS   = 8'h04;
    localparam logic [7:0] DEV_SHUTTER = 8'h06;
    localparam int unsigned MOVE_LEN   = 10;

    localparam int unsigned INDEX_W    = 4;
    localparam logic [INDEX_W-1:0] INDEX_MAX       = 4'd15;
    localparam logic [INDEX_W-1:0] MOVE_LAST_INDEX = INDEX_W'(MOVE_LEN - 1);
    localparam logic [INDEX_W-1:0] IDX_START       = 4'd0;
    localparam logic [INDEX_W-1:0] IDX_DEVICE      = 4'd1;
    localparam logic [INDEX_W-1:0] IDX_POS0        = 4'd4;
    localparam logic [INDEX_W-1:0] IDX_POS1        = 4'd5;
    localparam logic [INDEX_W-1:0] IDX_POS2        = 4'd6;
    localparam logic [INDEX_W-1:0] IDX_POS3        = 4'd7;
    localparam logic [INDEX_W-1:0] IDX_TAIL        = 4'd8;

    localparam int unsigned NUM_AXES = 3;
    localparam int unsigned AXIS_W   = $clog2(NUM_AXES);

    localparam logic [2:0] ST_MOVE_OK     = 3'd0;
    localparam logic [2:0] ST_SHUTTER_OK  = 3'd1;
    localparam logic [2:0] ST_BAD_START   = 3'd2;
    localparam logic [2:0] ST_UNKNOWN_DEV = 3'd3;
    localparam logic [2:0] ST_BAD_LENGTH  = 3'd4;
    localparam logic [2:0] ST_BAD_TAIL    = 3'd5;
    localparam logic [2:0] ST_BAD_CSUM    = 3'd6;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       frame_end;
    } request_t;

    typedef struct packed {
        logic [2:0]         status;
        logic [7:0]         device_id;
        logic signed [31:0] reported_position;
        logic signed [31:0] ir_position;
    } result_t;

    typedef struct packed {
        logic [2:0]         status;
        logic [7:0]         device;
        logic signed [31:0] position;
    } frame_t;

endpackage

// ----- hdl/mrfp_front.sv -----
`timescale 1ns / 1ps

module mrfp_front (
    input  logic                clk,
    input  logic                rst_n,
    input  mrfp_pkg::request_t  request,
    input  logic                take,
    output logic                frame_valid,
    output mrfp_pkg::frame_t    frame
);

    logic [mrfp_pkg::INDEX_W-1:0] byte_index_reg, byte_index_next;
    logic [7:0]  xor_reg, xor_next;
    logic [7:0]  start_reg, start_next;
    logic [7:0]  device_reg, device_next;
    logic [7:0]  tail_reg, tail_next;
    logic [31:0] pos_reg, pos_next;

    logic [7:0]  start_c, device_c, tail_c, xor_c;
    logic [31:0] pos_c;
    logic [2:0]  status_c;
    logic        last;

    assign last = take && request.frame_end;

    always_comb
    begin
        start_c  = (byte_index_reg == mrfp_pkg::IDX_START)  ? request.rx_byte : start_reg;
        device_c = (byte_index_reg == mrfp_pkg::IDX_DEVICE) ? request.rx_byte : device_reg;
        tail_c   = (byte_index_reg == mrfp_pkg::IDX_TAIL)   ? request.rx_byte : tail_reg;
        xor_c    = (byte_index_reg <= mrfp_pkg::IDX_TAIL) ? (xor_reg ^ request.rx_byte)
                                                            : xor_reg;
        pos_c    = pos_reg;
        case (byte_index_reg)
            mrfp_pkg::IDX_POS0: pos_c[7:0]   = request.rx_byte;
            mrfp_pkg::IDX_POS1: pos_c[15:8]  = request.rx_byte;
            mrfp_pkg::IDX_POS2: pos_c[23:16] = request.rx_byte;
            mrfp_pkg::IDX_POS3: pos_c[31:24] = request.rx_byte;
            default:            pos_c        = pos_reg;
        endcase
    end

    always_comb
    begin
        if (start_c != mrfp_pkg::START_MARK)
        begin
            status_c = mrfp_pkg::ST_BAD_START;
        end
        else if (device_c inside {mrfp_pkg::DEV_IR, mrfp_pkg::DEV_ZOOM, mrfp_pkg::DEV_FOCUS})
        begin
            if (byte_index_reg != mrfp_pkg::MOVE_LAST_INDEX)
                status_c = mrfp_pkg::ST_BAD_LENGTH;
            else if (tail_c != mrfp_pkg::TAIL_MARK)
                status_c = mrfp_pkg::ST_BAD_TAIL;
            else if (request.rx_byte != xor_reg)
                status_c = mrfp_pkg::ST_BAD_CSUM;
            else
                status_c = mrfp_pkg::ST_MOVE_OK;
        end
        else if (device_c == mrfp_pkg::DEV_SHUTTER)
        begin
            status_c = mrfp_pkg::ST_SHUTTER_OK;
        end
        else
        begin
            status_c = mrfp_pkg::ST_UNKNOWN_DEV;
        end
    end

    assign frame_valid    = last;
    assign frame.status   = status_c;
    assign frame.device   = device_c;
    assign frame.position = pos_c;

    always_comb
    begin
        byte_index_next = byte_index_reg;
        xor_next        = xor_reg;
        start_next      = start_reg;
        device_next     = device_reg;
        tail_next       = tail_reg;
        pos_next        = pos_reg;
        if (last)
        begin
            byte_index_next = '0;
            xor_next        = '0;
            start_next      = '0;
            device_next     = '0;
            tail_next       = '0;
            pos_next        = '0;
        end
        else if (take)
        begin
            if (byte_index_reg != mrfp_pkg::INDEX_MAX)
                byte_index_next = byte_index_reg + 4'd1;
            xor_next    = xor_c;
            start_next  = start_c;
            device_next = device_c;
            tail_next   = tail_c;
            pos_next    = pos_c;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_index_reg <= '0;
            xor_reg        <= '0;
            start_reg      <= '0;
            device_reg     <= '0;
            tail_reg       <= '0;
            pos_reg        <= '0;
        end
        else
        begin
            byte_index_reg <= byte_index_next;
            xor_reg        <= xor_next;
            start_reg      <= start_next;
            device_reg     <= device_next;
            tail_reg       <= tail_next;
            pos_reg        <= pos_next;
        end
    end

    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        last |=> (byte_index_reg == '0) && (xor_reg == '0) && (start_reg == '0))
        else $error("frame state not cleared after last byte");

    a_index_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !take |=> $stable(byte_index_reg))
        else $error("byte count moved without a request");

endmodule

// ----- hdl/mrfp_queue.sv -----
`timescale 1ns / 1ps

module mrfp_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  mrfp_pkg::frame_t  wr_data,
    output logic              full,
    input  logic              pop,
    output logic              empty,
    output mrfp_pkg::frame_t  rd_data
);

    mrfp_pkg::frame_t slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_push, do_pop;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_data = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_count_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg <= 2'd2) &&
        ((count_reg == 2'd1) == (wr_ptr_reg != rd_ptr_reg)))
        else $error("queue count and pointers disagree");

endmodule

// ----- hdl/mrfp_back.sv -----
`timescale 1ns / 1ps

module mrfp_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               frame_empty,
    input  mrfp_pkg::frame_t   frame,
    output logic               frame_pop,
    output mrfp_pkg::result_t  result,
    output logic               empty,
    input  logic               pop
);

    logic signed [31:0] axis_reg [mrfp_pkg::NUM_AXES];
    mrfp_pkg::result_t  slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       take, do_pop, move_ok;
    logic [mrfp_pkg::AXIS_W-1:0] axis_idx;
    logic [7:0] axis_off;
    mrfp_pkg::result_t res_c;

    assign take      = !frame_empty && (count_reg != 2'd2);
    assign frame_pop = take;
    assign do_pop    = pop && (count_reg != 2'd0);
    assign empty     = (count_reg == 2'd0);
    assign result    = slot_reg[rd_ptr_reg];

    assign move_ok  = (frame.status == mrfp_pkg::ST_MOVE_OK);
    assign axis_off = frame.device - mrfp_pkg::DEV_IR;
    assign axis_idx = axis_off[mrfp_pkg::AXIS_W-1:0];

    always_comb
    begin
        res_c.status            = frame.status;
        res_c.device_id         = frame.device;
        res_c.reported_position = frame.position;
        res_c.ir_position       = (move_ok && (axis_idx == '0)) ? frame.position : axis_reg[0];
    end

    always_comb
    begin
        wr_ptr_next = take ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, take} - {1'b0, do_pop};
    end

    always_ff @(posedge clk)
    begin
        if (take)
            slot_reg[wr_ptr_reg] <= res_c;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < mrfp_pkg::NUM_AXES; i++)
                axis_reg[i] <= '0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (take && move_ok)
                axis_reg[axis_idx] <= frame.position;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_move_device: assert property (@(posedge clk) disable iff (!rst_n)
        (take && move_ok) |-> (frame.device == mrfp_pkg::DEV_IR ||
                               frame.device == mrfp_pkg::DEV_ZOOM ||
                               frame.device == mrfp_pkg::DEV_FOCUS))
        else $error("move ok for a non-axis device");

endmodule

// ----- hdl/motor_reply_frame_parser.sv -----
`timescale 1ns / 1ps

// Motor reply frame parser.
// Request channel: one reply byte per request (rx_byte, frame_end set on the
// last byte of a frame). A request is taken when push is high and full low.
// Result channel: one result per frame, on the byte marked frame_end. The
// oldest result sits on result while empty is low and leaves on pop.
// The front stage tracks the byte count, XOR and captured bytes and
// classifies the frame on its last byte in the same cycle; the record goes
// through a two-entry queue to the back stage, which updates the stored axis
// position and writes a two-entry result buffer.
// A result reaches the result ports through the frame queue register and then the result buffer register.
// Throughput: one byte per cycle, sustained, as long as results are drained.
// If pop stays low the result buffer fills, then the frame queue; full rises
// once the frame queue holds two records and requests stall until it drains.
// Reset clears the frame capture state, all stored axis positions and both
// queues.
module motor_reply_frame_parser (
    input  logic               clk,
    input  logic               rst_n,
    input  mrfp_pkg::request_t request,
    input  logic               push,
    output logic               full,
    output mrfp_pkg::result_t  result,
    output logic               empty,
    input  logic               pop
);

    logic             take;
    logic             frame_valid;
    mrfp_pkg::frame_t frame_in, frame_out;
    logic             q_full, q_empty, q_pop;

    assign full = q_full;
    assign take = push && !q_full;

    mrfp_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .request     (request),
        .take        (take),
        .frame_valid (frame_valid),
        .frame       (frame_in)
    );

    mrfp_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (frame_valid),
        .wr_data (frame_in),
        .full    (q_full),
        .pop     (q_pop),
        .empty   (q_empty),
        .rd_data (frame_out)
    );

    mrfp_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .frame_empty (q_empty),
        .frame       (frame_out),
        .frame_pop   (q_pop),
        .result      (result),
        .empty       (empty),
        .pop         (pop)
    );

endmodule

// ----- dv/mrfp_checker.sv -----
`timescale 1ns / 1ps

module mrfp_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  mrfp_pkg::request_t  request,
    input  logic                push,
    input  logic                full,
    input  mrfp_pkg::result_t   result,
    input  logic                empty,
    input  logic                pop,
    output int unsigned         fail_count,
    output int unsigned         pending
);

    logic [mrfp_pkg::INDEX_W-1:0] byte_cnt;
    logic [7:0]                   run_xor;
    logic [7:0]                   start_cap;
    logic [7:0]                   dev_cap;
    logic [7:0]                   tail_cap;
    logic [31:0]                  pos_cap;
    logic signed [31:0]           axis_pos [mrfp_pkg::NUM_AXES];
    mrfp_pkg::result_t            replies_due [$];
    int unsigned                  mismatches;

    function automatic void clear_capture();
        byte_cnt  = '0;
        run_xor   = '0;
        start_cap = '0;
        dev_cap   = '0;
        tail_cap  = '0;
        pos_cap   = '0;
    endfunction

    // Absorbs one request; returns 1 with the frame reply when the byte ends a frame.
    function automatic bit parse_byte(input mrfp_pkg::request_t rq,
                                      output mrfp_pkg::result_t rs);
        logic [7:0] prior_xor;
        logic [2:0] st;
        bit         len_ok;
        rs = '0;
        prior_xor = run_xor;
        if (byte_cnt == mrfp_pkg::IDX_START)
            start_cap = rq.rx_byte;
        if (byte_cnt == mrfp_pkg::IDX_DEVICE)
            dev_cap = rq.rx_byte;
        if (byte_cnt >= mrfp_pkg::IDX_POS0 && byte_cnt <= mrfp_pkg::IDX_POS3)
            pos_cap[8*(int'(byte_cnt) - int'(mrfp_pkg::IDX_POS0)) +: 8] = rq.rx_byte;
        if (byte_cnt == mrfp_pkg::IDX_TAIL)
            tail_cap = rq.rx_byte;
        if (byte_cnt <= mrfp_pkg::IDX_TAIL)
            run_xor = run_xor ^ rq.rx_byte;
        len_ok = (int'(byte_cnt) + 1 == int'(mrfp_pkg::MOVE_LEN));
        if (byte_cnt != mrfp_pkg::INDEX_MAX)
            byte_cnt = byte_cnt + 1'b1;
        if (!rq.frame_end)
            return 1'b0;

        if (start_cap != mrfp_pkg::START_MARK)
            st = mrfp_pkg::ST_BAD_START;
        else if (dev_cap inside {mrfp_pkg::DEV_IR, mrfp_pkg::DEV_ZOOM, mrfp_pkg::DEV_FOCUS})
        begin
            if (!len_ok)
                st = mrfp_pkg::ST_BAD_LENGTH;
            else if (tail_cap != mrfp_pkg::TAIL_MARK)
                st = mrfp_pkg::ST_BAD_TAIL;
            else if (rq.rx_byte != prior_xor)
                st = mrfp_pkg::ST_BAD_CSUM;
            else
            begin
                st = mrfp_pkg::ST_MOVE_OK;
                axis_pos[int'(dev_cap - mrfp_pkg::DEV_IR)] = pos_cap;
            end
        end
        else if (dev_cap == mrfp_pkg::DEV_SHUTTER)
            st = mrfp_pkg::ST_SHUTTER_OK;
        else
            st = mrfp_pkg::ST_UNKNOWN_DEV;

        rs.status            = st;
        rs.device_id         = dev_cap;
        rs.reported_position = pos_cap;
        rs.ir_position       = axis_pos[0];
        clear_capture();
        return 1'b1;
    endfunction

    function automatic void report_miss(input string what, input mrfp_pkg::result_t want,
                                        input mrfp_pkg::result_t got);
        if (mismatches < 10)
        begin
            $display("%s: expected st=%0d dev=%02h pos=%08h ir=%08h",
                     what, want.status, want.device_id, want.reported_position,
                     want.ir_position);
            $display("    actual   st=%0d dev=%02h pos=%08h ir=%08h",
                     got.status, got.device_id, got.reported_position, got.ir_position);
        end
        mismatches++;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        mrfp_pkg::result_t got;
        mrfp_pkg::result_t want;
        mrfp_pkg::result_t fresh;
        if (!rst_n)
        begin
            clear_capture();
            foreach (axis_pos[i])
                axis_pos[i] = '0;
            replies_due.delete();
            mismatches = 0;
            fail_count <= 0;
            pending    <= 0;
        end
        else
        begin
            if (pop && !empty)
            begin
                got = result;
                if (replies_due.size() == 0)
                    report_miss("unexpected reply", '0, got);
                else
                begin
                    want = replies_due.pop_front();
                    if (got.status !== want.status || got.device_id !== want.device_id ||
                        got.reported_position !== want.reported_position ||
                        got.ir_position !== want.ir_position)
                        report_miss("reply mismatch", want, got);
                end
            end
            if (push && !full)
            begin
                if (parse_byte(request, fresh))
                    replies_due = {replies_due, fresh};
            end
            fail_count <= mismatches;
            pending    <= replies_due.size();
        end
    end

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

    localparam int unsigned BYTE_TARGET  = 1950;
    localparam int unsigned QUIET_FROM   = 1650;
    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned DRAIN_CYCLES = 10;

    typedef enum {
        FR_MOVE,
        FR_BAD_TAIL,
        FR_BAD_CSUM,
        FR_BAD_LEN,
        FR_SHUTTER,
        FR_UNKNOWN,
        FR_BAD_START,
        FR_NOISE
    } frame_kind_t;

    logic               clk;
    logic               rst_n;
    mrfp_pkg::request_t request;
    logic               push;
    logic               full;
    mrfp_pkg::result_t  result;
    logic               empty;
    logic               pop;
    int unsigned        fail_count;
    int unsigned        pending;

    logic        hold_pop;
    logic        quiet_end;
    logic [7:0]  frame_bytes [$];
    int unsigned bytes_sent;
    bit          gaps_on;
    int unsigned cycles;

    motor_reply_frame_parser dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request),
        .push    (push),
        .full    (full),
        .result  (result),
        .empty   (empty),
        .pop     (pop)
    );

    mrfp_checker u_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .request    (request),
        .push       (push),
        .full       (full),
        .result     (result),
        .empty      (empty),
        .pop        (pop),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [31:0] pick_position();
        case ($urandom_range(0, 11))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [7:0] move_dev();
        case ($urandom_range(0, 2))
            0:       return mrfp_pkg::DEV_IR;
            1:       return mrfp_pkg::DEV_ZOOM;
            default: return mrfp_pkg::DEV_FOCUS;
        endcase
    endfunction

    function automatic frame_kind_t pick_kind();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 40)      return FR_MOVE;
        else if (r < 50) return FR_BAD_TAIL;
        else if (r < 60) return FR_BAD_CSUM;
        else if (r < 70) return FR_BAD_LEN;
        else if (r < 80) return FR_SHUTTER;
        else if (r < 87) return FR_UNKNOWN;
        else if (r < 94) return FR_BAD_START;
        else             return FR_NOISE;
    endfunction

    task automatic build_move(input logic [7:0] dev, input logic [31:0] pos,
                              input logic [7:0] tail, input logic [7:0] csum_flip);
        logic [7:0] csum;
        frame_bytes = '{mrfp_pkg::START_MARK, dev, 8'($urandom), 8'($urandom),
                        pos[7:0], pos[15:8], pos[23:16], pos[31:24], tail};
        csum = '0;
        foreach (frame_bytes[i])
            csum = csum ^ frame_bytes[i];
        frame_bytes = {frame_bytes, csum ^ csum_flip};
    endtask

    task automatic fit_length(input int len);
        while (frame_bytes.size() > len)
            void'(frame_bytes.pop_back());
        while (frame_bytes.size() < len)
            frame_bytes = {frame_bytes, 8'($urandom)};
    endtask

    task automatic make_frame(input frame_kind_t kind);
        int         len;
        logic [7:0] b;
        case (kind)
            FR_MOVE:
                build_move(move_dev(), pick_position(), mrfp_pkg::TAIL_MARK, 8'h00);
            FR_BAD_TAIL:
            begin
                do b = 8'($urandom); while (b == mrfp_pkg::TAIL_MARK);
                build_move(move_dev(), pick_position(), b, 8'h00);
            end
            FR_BAD_CSUM:
                build_move(move_dev(), pick_position(), mrfp_pkg::TAIL_MARK,
                           8'($urandom_range(1, 255)));
            FR_BAD_LEN:
            begin
                if ($urandom_range(0, 3) == 0)
                    len = $urandom_range(16, 24);
                else
                    do len = $urandom_range(1, 15); while (len == int'(mrfp_pkg::MOVE_LEN));
                build_move(move_dev(), pick_position(), mrfp_pkg::TAIL_MARK, 8'h00);
                fit_length(len);
            end
            FR_SHUTTER:
            begin
                len = ($urandom_range(0, 3) == 0) ? $urandom_range(11, 20)
                                                  : $urandom_range(2, 10);
                frame_bytes = '{mrfp_pkg::START_MARK, mrfp_pkg::DEV_SHUTTER};
                fit_length(len);
            end
            FR_UNKNOWN:
            begin
                do b = 8'($urandom);
                while (b inside {mrfp_pkg::DEV_IR, mrfp_pkg::DEV_ZOOM,
                                 mrfp_pkg::DEV_FOCUS, mrfp_pkg::DEV_SHUTTER});
                frame_bytes = '{mrfp_pkg::START_MARK, b};
                fit_length($urandom_range(2, 12));
            end
            FR_BAD_START:
            begin
                do b = 8'($urandom); while (b == mrfp_pkg::START_MARK);
                build_move(move_dev(), pick_position(), mrfp_pkg::TAIL_MARK, 8'h00);
                frame_bytes[0] = b;
                fit_length($urandom_range(1, 12));
            end
            default:
            begin
                frame_bytes.delete();
                fit_length($urandom_range(1, 20));
            end
        endcase
    endtask

    // Returns at the edge where the request is taken.
    task automatic send_req(input logic [7:0] b, input logic last);
        request <= '{rx_byte: b, frame_end: last};
        push    <= 1'b1;
        do @(posedge clk); while (full);
    endtask

    task automatic send_frame();
        for (int i = 0; i < frame_bytes.size(); i++)
        begin
            send_req(frame_bytes[i], i == frame_bytes.size() - 1);
            bytes_sent++;
            if (gaps_on && bytes_sent < QUIET_FROM && $urandom_range(0, 7) == 0)
            begin
                push <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge clk);
            end
        end
    endtask

    initial
    begin : drain_side
        int unsigned stall_left;
        stall_left = 0;
        pop = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (stall_left != 0)
                stall_left--;
            else if (!quiet_end && $urandom_range(0, 9) == 0)
                stall_left = $urandom_range(1, 14);
            pop <= !hold_pop && (stall_left == 0);
        end
    end

    // Long receiver hold-off so the block backs up and raises full.
    initial
    begin : hold_off
        hold_pop = 1'b0;
        @(posedge rst_n);
        repeat (400) @(posedge clk);
        hold_pop <= 1'b1;
        repeat (250) @(posedge clk);
        hold_pop <= 1'b0;
    end

    initial
    begin : watchdog
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Some tests failed");
        $finish;
    end

    initial
    begin : stimulus
        rst_n      = 1'b0;
        push       = 1'b0;
        request    = '0;
        quiet_end  = 1'b0;
        gaps_on    = 1'b1;
        bytes_sent = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        build_move(mrfp_pkg::DEV_IR, 32'h8000_0000, mrfp_pkg::TAIL_MARK, 8'h00);
        send_frame();
        build_move(mrfp_pkg::DEV_FOCUS, 32'h7FFF_FFFF, mrfp_pkg::TAIL_MARK, 8'h00);
        send_frame();
        frame_bytes = '{8'hFF};
        send_frame();
        frame_bytes = '{mrfp_pkg::START_MARK};
        send_frame();
        frame_bytes = '{mrfp_pkg::START_MARK, mrfp_pkg::DEV_SHUTTER};
        send_frame();
        frame_bytes = '{mrfp_pkg::START_MARK, 8'hFF};
        send_frame();
        frame_bytes = '{mrfp_pkg::START_MARK, mrfp_pkg::DEV_ZOOM, 8'h00};
        send_frame();

        while (bytes_sent < BYTE_TARGET)
        begin
            gaps_on = ($urandom_range(0, 3) != 0);
            if (bytes_sent >= QUIET_FROM)
                quiet_end <= 1'b1;
            make_frame(pick_kind());
            send_frame();
        end
        push <= 1'b0;

        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
